>>> rtl/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// shared types, command codes and character constants for the integer to ascii formatter
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam logic [1:0] CMD_UDEC = 2'd0;
    localparam logic [1:0] CMD_SDEC = 2'd1;
    localparam logic [1:0] CMD_HEXL = 2'd2;
    localparam logic [1:0] CMD_HEXU = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    localparam int TEXT_BUF = 24;
    localparam int DIG_W    = 5;
    localparam int LEN_W    = 7;

    typedef struct packed {
        logic [LEN_W-1:0] pad;
        logic             neg;
        logic [DIG_W-1:0] nd;
        logic             zpad;
    } fmt_info_t;

endpackage

>>> rtl/integer_to_ascii_field_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_field_formatter
// formats one number as an ascii field, one character per output transaction
// ----------------------------------------------------------------------------
// An input transaction passes a sign stage, an input register, a pipeline of 24
// digit stages (one divide by the base per stage: a reciprocal multiply by a
// tenth, or a shift for hex) and a pad stage, so a new number can enter every
// cycle while the output side does not hold the pipeline. The output side sends
// one character per cycle while the receiver is ready and takes the next number
// only from its idle state, after the last character of a field (pad + sign +
// digits, at least one); that character sequencer sets throughput.
module integer_to_ascii_field_formatter
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_FIELD_WIDTH = 63
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // cmd[1:0], value[VALUE_BITS+1:2], field_width, zero_pad, zero fill
    input  logic [((VALUE_BITS+9+7)/8)*8-1:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // ch[7:0]
    output logic [7:0]  m_tdata,
    output logic        m_tlast
);

    logic [1:0]            p_cmd;
    logic [VALUE_BITS-1:0] p_mag;
    logic                  p_neg, p_valid, p_ready, p_zpad;
    logic [5:0]            p_width;
    logic                  c_valid, c_ready;
    logic [TEXT_BUF*8-1:0] c_digits;
    fmt_info_t             c_info;

    itoa_prep #(.VALUE_BITS(VALUE_BITS)) u_prep (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_cmd(s_tdata[1:0]), .in_value(s_tdata[VALUE_BITS+1:2]),
        .in_width(s_tdata[VALUE_BITS+7:VALUE_BITS+2]),
        .in_zpad(s_tdata[VALUE_BITS+8]),
        .out_valid(p_valid), .out_ready(p_ready),
        .out_cmd(p_cmd), .out_mag(p_mag), .out_neg(p_neg),
        .out_width(p_width), .out_zpad(p_zpad)
    );

    itoa_conv #(.VALUE_BITS(VALUE_BITS), .MAX_FIELD_WIDTH(MAX_FIELD_WIDTH)) u_conv (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(p_valid), .in_ready(p_ready),
        .in_cmd(p_cmd), .in_mag(p_mag), .in_neg(p_neg),
        .in_width(p_width), .in_zpad(p_zpad),
        .out_valid(c_valid), .out_ready(c_ready),
        .out_digits(c_digits), .out_info(c_info)
    );

    itoa_emit u_emit (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(c_valid), .in_ready(c_ready),
        .in_digits(c_digits), .in_info(c_info),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .out_ch(m_tdata), .out_last(m_tlast)
    );

endmodule

>>> rtl/itoa_prep.sv
// ----------------------------------------------------------------------------
// itoa_prep
// front stage: sign handling and magnitude
// ----------------------------------------------------------------------------
module itoa_prep
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_cmd,
    input  logic [VALUE_BITS-1:0] in_value,
    input  logic [5:0]            in_width,
    input  logic                  in_zpad,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            out_cmd,
    output logic [VALUE_BITS-1:0] out_mag,
    output logic                  out_neg,
    output logic [5:0]            out_width,
    output logic                  out_zpad
);

    logic                  valid_reg;
    logic [1:0]            cmd_reg;
    logic [VALUE_BITS-1:0] mag_reg;
    logic                  neg_reg;
    logic [5:0]            width_reg;
    logic                  zpad_reg;
    logic                  neg_next;

    assign in_ready = !valid_reg || out_ready;
    assign neg_next = (in_cmd == CMD_SDEC) && in_value[VALUE_BITS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            cmd_reg   <= in_cmd;
            neg_reg   <= neg_next;
            mag_reg   <= neg_next ? (~in_value + 1'b1) : in_value;
            width_reg <= in_width;
            zpad_reg  <= in_zpad;
        end
    end

    assign out_valid = valid_reg;
    assign out_cmd   = cmd_reg;
    assign out_mag   = mag_reg;
    assign out_neg   = neg_reg;
    assign out_width = width_reg;
    assign out_zpad  = zpad_reg;

endmodule

>>> rtl/itoa_conv.sv
// ----------------------------------------------------------------------------
// itoa_conv
// digit conversion: one digit per pipeline stage, least significant first
// ----------------------------------------------------------------------------
module itoa_conv
    import itoa_pkg::*;
#(
    parameter int VALUE_BITS = 32,
    parameter int MAX_FIELD_WIDTH = 63
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [1:0]            in_cmd,
    input  logic [VALUE_BITS-1:0] in_mag,
    input  logic                  in_neg,
    input  logic [5:0]            in_width,
    input  logic                  in_zpad,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [TEXT_BUF*8-1:0] out_digits,
    output fmt_info_t             out_info
);

    localparam int NSTG = TEXT_BUF;

    // ceil(2^(VALUE_BITS+3) / 10), quotient is exact for every value of the width
    localparam logic [VALUE_BITS+3:0] DIV10_ONE = (VALUE_BITS+4)'(1) << (VALUE_BITS + 3);
    localparam logic [VALUE_BITS-1:0] DIV10_MUL =
        VALUE_BITS'((DIV10_ONE + (VALUE_BITS+4)'(9)) / (VALUE_BITS+4)'(10));

    logic                  v_reg   [NSTG+1];
    logic [1:0]            cmd_reg [NSTG+1];
    logic [VALUE_BITS-1:0] num_reg [NSTG+1];
    logic                  neg_reg [NSTG+1];
    logic [5:0]            w_reg   [NSTG+1];
    logic                  zp_reg  [NSTG+1];
    logic [DIG_W-1:0]      nd_reg  [NSTG+1];
    logic [TEXT_BUF*8-1:0] dg_reg  [NSTG+1];
    logic                  adv     [1:NSTG];

    logic                  fv_reg;
    logic [TEXT_BUF*8-1:0] fdg_reg;
    fmt_info_t             finfo_reg;
    logic                  fadv;

    assign fadv = !fv_reg || out_ready;
    assign adv[NSTG] = !v_reg[NSTG] || fadv;
    assign in_ready = !v_reg[0] || adv[1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (in_ready) begin
            v_reg[0] <= in_valid;
        end
        if (in_ready && in_valid) begin
            cmd_reg[0] <= in_cmd;
            num_reg[0] <= in_mag;
            neg_reg[0] <= in_neg;
            w_reg[0]   <= (6'(MAX_FIELD_WIDTH) < in_width) ? 6'(MAX_FIELD_WIDTH) : in_width;
            zp_reg[0]  <= in_zpad;
            nd_reg[0]  <= '0;
            dg_reg[0]  <= '0;
        end
    end

    for (genvar s = 1; s <= NSTG; s++) begin : g_stg
        logic                    hex;
        logic                    busy;
        logic [2*VALUE_BITS-1:0] recip;
        logic [VALUE_BITS-1:0]   quo;
        logic [3:0]              rem;
        logic [7:0]              chr;
        logic [VALUE_BITS+3:0]   prod;
        logic [TEXT_BUF*8-1:0]   dg_next;

        if (s < NSTG) begin : g_adv
            assign adv[s] = !v_reg[s] || adv[s+1];
        end

        assign hex   = cmd_reg[s-1][1];
        assign busy  = (nd_reg[s-1] == '0) || (num_reg[s-1] != '0);
        assign recip = (2*VALUE_BITS)'(num_reg[s-1]) * (2*VALUE_BITS)'(DIV10_MUL);
        assign quo   = hex ? (num_reg[s-1] >> 4) : (recip[2*VALUE_BITS-1:VALUE_BITS] >> 3);
        assign prod  = {4'd0, quo} * (VALUE_BITS + 4)'(10);
        assign rem   = hex ? num_reg[s-1][3:0]
                           : 4'(num_reg[s-1] - prod[VALUE_BITS-1:0]);
        assign chr   = (rem < 4'd10) ? (CH_ZERO + 8'(rem))
                     : (((cmd_reg[s-1] == CMD_HEXU) ? CH_UA : CH_LA) + 8'(rem) - 8'd10);

        always_comb begin
            dg_next = dg_reg[s-1];
            if (busy) begin
                dg_next[(s-1)*8 +: 8] = chr;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[s] <= 1'b0;
            end else if (adv[s]) begin
                v_reg[s] <= v_reg[s-1];
            end
            if (adv[s] && v_reg[s-1]) begin
                cmd_reg[s] <= cmd_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
                w_reg[s]   <= w_reg[s-1];
                zp_reg[s]  <= zp_reg[s-1];
                num_reg[s] <= busy ? quo : num_reg[s-1];
                nd_reg[s]  <= busy ? nd_reg[s-1] + 1'b1 : nd_reg[s-1];
                dg_reg[s]  <= dg_next;
            end
        end
    end

    logic [LEN_W-1:0] tlen;
    assign tlen = LEN_W'(nd_reg[NSTG]) + LEN_W'(neg_reg[NSTG]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fv_reg <= 1'b0;
        end else if (fadv) begin
            fv_reg <= v_reg[NSTG];
        end
        if (fadv && v_reg[NSTG]) begin
            fdg_reg        <= dg_reg[NSTG];
            finfo_reg.nd   <= nd_reg[NSTG];
            finfo_reg.neg  <= neg_reg[NSTG];
            finfo_reg.zpad <= zp_reg[NSTG];
            finfo_reg.pad  <= (LEN_W'(w_reg[NSTG]) > tlen) ? LEN_W'(w_reg[NSTG]) - tlen : '0;
        end
    end

    assign out_valid  = fv_reg;
    assign out_digits = fdg_reg;
    assign out_info   = finfo_reg;

endmodule

>>> rtl/itoa_emit.sv
// ----------------------------------------------------------------------------
// itoa_emit
// character sequencer: pad, sign, then digits most significant first
// ----------------------------------------------------------------------------
module itoa_emit
    import itoa_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [TEXT_BUF*8-1:0] in_digits,
    input  fmt_info_t             in_info,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            out_ch,
    output logic                  out_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PAD  = 2'd1;
    localparam logic [1:0] ST_SIGN = 2'd2;
    localparam logic [1:0] ST_DIG  = 2'd3;

    logic [1:0]            state_reg, state_next;
    logic [TEXT_BUF*8-1:0] dg_reg;
    fmt_info_t             info_reg;
    logic [LEN_W-1:0]      cnt_reg, cnt_next;
    logic [DIG_W-1:0]      idx_reg, idx_next;
    logic                  ov_reg;
    logic [7:0]            och_reg;
    logic                  olast_reg;
    logic                  emit;
    logic [7:0]            ch;
    logic                  lst;
    logic                  can;

    assign can      = !ov_reg || out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign emit     = (state_reg != ST_IDLE) && can;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        idx_next   = idx_reg;
        ch         = CH_SPACE;
        lst        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cnt_next = in_info.pad;
                    idx_next = in_info.nd - 1'b1;
                    if (in_info.pad != '0) begin
                        state_next = ST_PAD;
                    end else if (in_info.neg) begin
                        state_next = ST_SIGN;
                    end else begin
                        state_next = ST_DIG;
                    end
                end
            end
            ST_PAD: begin
                ch = info_reg.zpad ? CH_ZERO : CH_SPACE;
                if (can) begin
                    cnt_next = cnt_reg - 1'b1;
                    if (cnt_reg == LEN_W'(1)) begin
                        state_next = info_reg.neg ? ST_SIGN : ST_DIG;
                    end
                end
            end
            ST_SIGN: begin
                ch = CH_MINUS;
                if (can) begin
                    state_next = ST_DIG;
                end
            end
            ST_DIG: begin
                ch  = dg_reg[idx_reg*8 +: 8];
                lst = (idx_reg == '0);
                if (can) begin
                    idx_next = idx_reg - 1'b1;
                    if (lst) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (emit) begin
                ov_reg <= 1'b1;
            end else if (out_ready) begin
                ov_reg <= 1'b0;
            end
        end
        cnt_reg <= cnt_next;
        idx_reg <= idx_next;
        if (in_ready && in_valid) begin
            dg_reg   <= in_digits;
            info_reg <= in_info;
        end
        if (emit) begin
            och_reg   <= ch;
            olast_reg <= lst;
        end
    end

    assign out_valid = ov_reg;
    assign out_ch    = och_reg;
    assign out_last  = olast_reg;

endmodule

>>> rtl/itoa_checker.sv
// ----------------------------------------------------------------------------
// itoa_checker
// port-level checks on the formatter's output stream
// ----------------------------------------------------------------------------
module itoa_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // held output stays
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // last character is always a digit
    a_last_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata >= 8'h30 && m_tdata <= 8'h39)
            || (m_tdata >= 8'h41 && m_tdata <= 8'h46)
            || (m_tdata >= 8'h61 && m_tdata <= 8'h66))
        else $error("field ends in non-digit");

    // a minus sign is never the last character
    a_minus: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata == 8'h2d |-> !m_tlast)
        else $error("minus closes field");

    // no valid during reset release
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("valid after reset");

endmodule

bind integer_to_ascii_field_formatter itoa_checker u_itoa_checker (
    .aclk(aclk), .aresetn(aresetn), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);

>>> tb/tb_integer_to_ascii_field_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_field_formatter
// drives directed corner cases and numbers with random mode, width and pad choice into the formatter
// and compares every character against an in-bench formatting model
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_field_formatter;
    import itoa_pkg::*;

    localparam int VB = 32;
    localparam int DW = ((VB + 9 + 7) / 8) * 8;
    localparam int LIMIT = 2000000;
    localparam int DRAIN = 60;

    typedef struct packed {
        logic       zpad;
        logic [5:0] fw;
        logic [31:0] value;
        logic [1:0] cmd;
    } num_req_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_tvalid = 0;
    logic s_tready;
    logic [DW-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 0;
    logic [7:0] m_tdata;
    logic m_tlast;
    logic in_fire = 0;

    num_req_t pending_nums[$];
    char_t    expected_chars[$];
    int errors = 0;
    int chars_seen = 0;
    int nums_sent = 0;
    int cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_off = 0;
    bit hold_req = 0;
    bit hold_done = 0;
    bit pause_req = 0;

    integer_to_ascii_field_formatter uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic format_number(input num_req_t n);
        logic [7:0] digits[24];
        logic [31:0] mag;
        logic [3:0] d;
        logic [7:0] alpha;
        int nd, base, textlen, pad, total, k;
        bit neg;
        char_t c;
        mag = n.value;
        neg = 0;
        nd = 0;
        k = 0;
        base = (n.cmd == CMD_HEXL || n.cmd == CMD_HEXU) ? 16 : 10;
        alpha = (n.cmd == CMD_HEXU) ? CH_UA : CH_LA;
        if (n.cmd == CMD_SDEC && mag[31]) begin
            neg = 1;
            mag = -mag;
        end
        do begin
            d = 4'(mag % base);
            mag = 32'(mag / base);
            digits[nd] = (d < 4'd10) ? CH_ZERO + 8'(d) : alpha + 8'(d) - 8'd10;
            nd++;
        end while (mag != 0);
        textlen = nd + int'(neg);
        pad = (int'(n.fw) > textlen) ? int'(n.fw) - textlen : 0;
        total = pad + textlen;
        repeat (pad) begin
            c.ch = n.zpad ? CH_ZERO : CH_SPACE;
            c.last = (k == total - 1);
            expected_chars.push_back(c);
            k++;
        end
        if (neg) begin
            c.ch = CH_MINUS;
            c.last = (k == total - 1);
            expected_chars.push_back(c);
            k++;
        end
        while (nd > 0) begin
            nd--;
            c.ch = digits[nd];
            c.last = (k == total - 1);
            expected_chars.push_back(c);
            k++;
        end
    endtask

    task automatic add_num(input logic [1:0] cmd, input logic [31:0] v,
                           input logic [5:0] fw, input logic zp);
        num_req_t n;
        n.cmd = cmd;
        n.value = v;
        n.fw = fw;
        n.zpad = zp;
        pending_nums.push_back(n);
    endtask

    function automatic logic [31:0] rand_value();
        int r;
        r = $urandom_range(0, 5);
        case (r)
            0: return $urandom_range(0, 20);
            1: return 32'hffff_ffff - $urandom_range(0, 20);
            2: return {1'b1, 31'($urandom_range(0, 10))};
            3: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (in_fire) begin
                format_number(num_req_t'(s_tdata[40:0]));
                nums_sent++;
            end
            if (!s_tvalid || in_fire) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 0;
                end else if (pending_nums.size() > 0 &&
                             !(pause_req && expected_chars.size() > 0)) begin
                    s_tdata <= DW'(pending_nums.pop_front());
                    s_tvalid <= 1;
                    send_gap <= (hold_off > 0) ? 0 : rand_gap();
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (aresetn) begin
            if (hold_req && !hold_done) begin
                hold_off <= 300;
                hold_done <= 1;
                m_tready <= 0;
            end else if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_tready <= (hold_off == 1);
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 0;
            end else begin
                m_tready <= 1;
                recv_gap <= rand_gap();
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        in_fire <= aresetn && s_tvalid && s_tready;
        if (aresetn && m_tvalid && m_tready) begin
            chars_seen <= chars_seen + 1;
            if (expected_chars.size() == 0) begin
                $display("%0t unexpected char: expected none, actual ch=%h last=%b",
                         $time, m_tdata, m_tlast);
                errors <= errors + 1;
            end else begin
                char_t e;
                e = expected_chars.pop_front();
                if (e.ch !== m_tdata || e.last !== m_tlast) begin
                    $display("%0t mismatch: expected ch=%h last=%b, actual ch=%h last=%b",
                             $time, e.ch, e.last, m_tdata, m_tlast);
                    errors <= errors + 1;
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int i;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        // directed corner cases
        add_num(CMD_UDEC, 0, 0, 0);
        add_num(CMD_UDEC, 32'hffff_ffff, 0, 0);
        add_num(CMD_SDEC, 32'h8000_0000, 0, 0);
        add_num(CMD_SDEC, 32'h8000_0000, 63, 1);
        add_num(CMD_SDEC, 32'hffff_ffff, 8, 1);
        add_num(CMD_SDEC, 32'hffff_ff85, 8, 0);
        add_num(CMD_SDEC, 32'h7fff_ffff, 5, 0);
        add_num(CMD_HEXL, 32'hdead_beef, 0, 0);
        add_num(CMD_HEXU, 32'hdead_beef, 12, 1);
        add_num(CMD_HEXU, 0, 63, 0);
        add_num(CMD_HEXL, 32'h0000_abcd, 3, 1);
        add_num(CMD_UDEC, 42, 1, 1);
        add_num(CMD_UDEC, 1234567890, 10, 0);
        add_num(CMD_UDEC, 7, 63, 1);
        add_num(CMD_HEXL, 32'hffff_ffff, 9, 0);
        add_num(CMD_SDEC, 0, 2, 1);
        wait (pending_nums.size() == 0);
        // sender waits for every expected character before each number of this random batch
        pause_req = 1;
        for (i = 0; i < 20; i++)
            add_num(2'($urandom_range(0, 3)), rand_value(), 6'($urandom_range(0, 63)),
                    1'($urandom));
        wait (pending_nums.size() == 0 && expected_chars.size() == 0);
        pause_req = 0;
        // long receiver stall with the sender still offering
        hold_req = 1;
        for (i = 0; i < 134; i++) begin
            if ($urandom_range(0, 9) < 8)
                add_num(2'($urandom_range(0, 3)), rand_value(), 6'($urandom_range(0, 14)),
                        1'($urandom));
            else
                add_num(2'($urandom_range(0, 3)), rand_value(), 6'($urandom_range(0, 63)),
                        1'($urandom));
        end
        wait (pending_nums.size() == 0 && !s_tvalid);
        wait (expected_chars.size() == 0);
        repeat (DRAIN) @(posedge aclk);
        $display("sent %0d numbers in all four modes, checked %0d characters",
                 nums_sent, chars_seen);
        if (errors == 0 && expected_chars.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
